// ===== rtl/core/bpm_pkg.sv =====
`timescale 1ns / 1ps

package bpm_pkg;

    localparam int NUM_ENTRIES_DEF = 32;
    localparam int ADDR_WIDTH_DEF  = 32;

    localparam int MODE_W    = 2;
    localparam int IN_ADDR_W = 32;
    localparam int SLOT_W    = 5;
    localparam int HIT_W     = 32;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int CMD_W_DEF   = MODE_W + IN_ADDR_W + SLOT_W + 1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SET   = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CHECK = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

endpackage

// ===== rtl/core/bpm_ram.sv =====
`timescale 1ns / 1ps

module bpm_ram
    import bpm_pkg::*;
#(
    parameter int WIDTH = HIT_W,
    parameter int DEPTH = NUM_ENTRIES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/bpm_front.sv =====
`timescale 1ns / 1ps

module bpm_front
    import bpm_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
    localparam int KEY_W = (ADDR_WIDTH < IN_ADDR_W) ? ADDR_WIDTH : IN_ADDR_W,
    localparam int CMD_W = MODE_W + KEY_W + SLOT_W + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [IN_ADDR_W-1:0] i_target_address,
    input  logic [SLOT_W-1:0]    i_slot_number,
    output logic                 o_push,
    output logic [CMD_W-1:0]     o_cmd,
    input  logic                 i_full
);

    logic             r_valid;
    logic             n_valid;
    logic [CMD_W-1:0] r_cmd;
    logic [CMD_W-1:0] n_cmd;
    logic             accept;
    logic             slot_ok;
    t_mode            mode;
    logic [KEY_W-1:0] key;

    assign o_stall = r_valid & i_full;
    assign accept  = i_valid & ~o_stall;
    assign o_push  = r_valid & ~i_full;
    assign o_cmd   = r_cmd;

    // classify: decode mode, trim address, range-check the slot
    always_comb begin
        mode    = t_mode'(i_mode);
        key     = KEY_W'(i_target_address);
        slot_ok = (32'(i_slot_number) < 32'(NUM_ENTRIES));
        n_cmd   = {mode, key, i_slot_number, slot_ok};
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/core/bpm_queue.sv =====
`timescale 1ns / 1ps

module bpm_queue
    import bpm_pkg::*;
#(
    parameter int WIDTH = CMD_W_DEF,
    parameter int DEPTH = QUEUE_DEPTH,
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= next_ptr(r_wr);
            end
            if (do_pop) begin
                r_rd <= next_ptr(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/core/bpm_exec.sv =====
`timescale 1ns / 1ps

module bpm_exec
    import bpm_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
    localparam int KEY_W = (ADDR_WIDTH < IN_ADDR_W) ? ADDR_WIDTH : IN_ADDR_W,
    localparam int CMD_W = MODE_W + KEY_W + SLOT_W + 1,
    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
    localparam int CNT_W = $clog2(NUM_ENTRIES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [CMD_W-1:0]     i_cmd,
    input  logic                 i_empty,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_ok,
    output logic                 o_hit,
    output logic [SLOT_W-1:0]    o_result_number,
    output logic [IN_ADDR_W-1:0] o_entry_address,
    output logic [HIT_W-1:0]     o_hit_count
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [CMD_W-1:0]       r_cmd;
    logic [NUM_ENTRIES-1:0] r_active;
    logic [KEY_W-1:0]       r_key   [NUM_ENTRIES];
    logic [NUM_ENTRIES-1:0] r_older [NUM_ENTRIES];
    logic [CNT_W-1:0]       r_free_cnt;
    logic [CNT_W-1:0]       r_low;

    logic                 r_out_valid;
    logic                 r_ok;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_num;
    logic [IN_ADDR_W-1:0] r_eaddr;
    logic [HIT_W-1:0]     r_cnt;

    t_mode             cmd_mode;
    logic [KEY_W-1:0]  cmd_key;
    logic [SLOT_W-1:0] cmd_slot;
    logic              cmd_slot_ok;
    logic [IDX_W-1:0]  slot_idx;
    logic              slot_act;
    logic              free_ok;

    logic [NUM_ENTRIES-1:0] match;
    logic [NUM_ENTRIES-1:0] win;
    logic [IDX_W-1:0]       win_idx;
    logic                   any_match;

    logic [IDX_W-1:0] top_num;
    logic [IDX_W-1:0] st_rdata;
    logic             st_we;
    logic [HIT_W-1:0] hit_rdata;
    logic [HIT_W-1:0] hit_inc;
    logic             hit_we;
    logic [IDX_W-1:0] hit_waddr;
    logic [HIT_W-1:0] hit_wdata;
    logic [IDX_W-1:0] hit_raddr;

    logic                 emit;
    logic                 do_set;
    logic                 do_free;
    logic                 e_ok;
    logic                 e_hit;
    logic [SLOT_W-1:0]    e_num;
    logic [IN_ADDR_W-1:0] e_addr;
    logic [HIT_W-1:0]     e_cnt;

    assign cmd_mode    = t_mode'(r_cmd[CMD_W-1 -: MODE_W]);
    assign cmd_key     = r_cmd[SLOT_W+1 +: KEY_W];
    assign cmd_slot    = r_cmd[1 +: SLOT_W];
    assign cmd_slot_ok = r_cmd[0];
    assign slot_idx    = IDX_W'(cmd_slot);
    assign slot_act    = cmd_slot_ok && r_active[slot_idx];
    assign free_ok     = slot_act && (r_free_cnt < CNT_W'(NUM_ENTRIES));

    assign o_pop = (r_state == S_IDLE) && !i_empty && (!r_out_valid || !i_stall);

    // match every entry; the oldest match wins via the age matrix
    always_comb begin
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            match[i] = r_active[i] && (r_key[i] == cmd_key);
        end
        win_idx = '0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            win[i] = match[i] && !(|(match & r_older[i]));
            if (win[i]) begin
                win_idx = win_idx | IDX_W'(i);
            end
        end
        any_match = |match;
    end

    // below the low-water mark the free stack still holds its reset order
    assign top_num = (r_free_cnt <= r_low) ? IDX_W'(CNT_W'(NUM_ENTRIES) - r_free_cnt)
                                           : st_rdata;
    assign st_we     = do_free;
    assign hit_raddr = (cmd_mode == MODE_CHECK) ? win_idx : slot_idx;
    assign hit_inc   = (hit_rdata == HIT_MAX) ? hit_rdata : hit_rdata + 1'b1;

    bpm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_ENTRIES)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (IDX_W'(r_free_cnt)),
        .i_wdata (slot_idx),
        .i_raddr (IDX_W'(r_free_cnt - 1'b1)),
        .o_rdata (st_rdata)
    );

    bpm_ram #(
        .WIDTH (HIT_W),
        .DEPTH (NUM_ENTRIES)
    ) u_hits (
        .i_clk   (i_clk),
        .i_we    (hit_we),
        .i_waddr (hit_waddr),
        .i_wdata (hit_wdata),
        .i_raddr (hit_raddr),
        .o_rdata (hit_rdata)
    );

    always_comb begin
        n_state   = r_state;
        emit      = 1'b0;
        do_set    = 1'b0;
        do_free   = 1'b0;
        e_ok      = 1'b0;
        e_hit     = 1'b0;
        e_num     = '0;
        e_addr    = '0;
        e_cnt     = '0;
        hit_we    = 1'b0;
        hit_waddr = top_num;
        hit_wdata = '0;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (cmd_mode)
                    MODE_SET: begin
                        if (r_free_cnt != '0) begin
                            n_state = S_FIN;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                    MODE_FREE: begin
                        emit = 1'b1;
                        if (free_ok) begin
                            do_free = 1'b1;
                            e_ok    = 1'b1;
                        end
                    end
                    MODE_CHECK: begin
                        if (any_match) begin
                            n_state = S_FIN;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                    default: begin
                        e_num = cmd_slot;
                        if (slot_act) begin
                            n_state = S_FIN;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                endcase
            end
            S_FIN: begin
                n_state = S_IDLE;
                emit    = 1'b1;
                case (cmd_mode)
                    MODE_SET: begin
                        do_set    = 1'b1;
                        e_ok      = 1'b1;
                        e_num     = SLOT_W'(top_num);
                        hit_we    = 1'b1;
                        hit_waddr = top_num;
                        hit_wdata = '0;
                    end
                    MODE_CHECK: begin
                        e_hit     = 1'b1;
                        e_num     = SLOT_W'(win_idx);
                        e_cnt     = hit_inc;
                        hit_we    = 1'b1;
                        hit_waddr = win_idx;
                        hit_wdata = hit_inc;
                    end
                    default: begin
                        e_ok   = 1'b1;
                        e_num  = cmd_slot;
                        e_addr = IN_ADDR_W'(r_key[slot_idx]);
                        e_cnt  = hit_rdata;
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_active    <= '0;
            r_free_cnt  <= CNT_W'(NUM_ENTRIES);
            r_low       <= CNT_W'(NUM_ENTRIES);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (do_free) begin
                r_active[slot_idx] <= 1'b0;
                r_free_cnt         <= r_free_cnt + 1'b1;
            end
            if (do_set) begin
                r_active[top_num] <= 1'b1;
                r_free_cnt        <= r_free_cnt - 1'b1;
                if (r_free_cnt <= r_low) begin
                    r_low <= r_free_cnt - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (emit) begin
            r_ok    <= e_ok;
            r_hit   <= e_hit;
            r_num   <= e_num;
            r_eaddr <= e_addr;
            r_cnt   <= e_cnt;
        end
        if (do_set) begin
            r_key[top_num]   <= cmd_key;
            r_older[top_num] <= r_active;
            for (int i = 0; i < NUM_ENTRIES; i++) begin
                if (IDX_W'(i) != top_num) begin
                    r_older[i][top_num] <= 1'b0;
                end
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_ok            = r_ok;
    assign o_hit           = r_hit;
    assign o_result_number = r_num;
    assign o_entry_address = r_eaddr;
    assign o_hit_count     = r_cnt;

    a_single_winner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(win))
        else $error("more than one oldest match");

    a_pool_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(r_active) + int'(r_free_cnt)) == NUM_ENTRIES)
        else $error("free and active entries do not add up");

    a_pop_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && cmd_mode == MODE_SET) |-> !r_active[top_num])
        else $error("free stack handed out an active number");

    a_emit_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> !r_out_valid)
        else $error("result word overwritten");

endmodule

// ===== rtl/core/breakpoint_pool_match_top.sv =====
`timescale 1ns / 1ps

// Breakpoint pool with address match.
// Input channel: i_valid / o_stall carry one request word (mode, target address,
// slot number). Output channel: o_valid / i_stall carry one result word per
// request. A word moves on a rising edge with valid high and stall low.
// Modes: set takes the most recently freed number, free returns one, check
// matches an address against all active entries (oldest entry counts the hit,
// count saturates), read returns one entry.
// A request passes the input register, queue and exec command register; its
// result is registered from S_EXEC for free, a failed set, a check miss or an
// inactive read, and from S_FIN for the rest. The sequencer runs one request
// at a time (S_IDLE, S_EXEC, S_FIN for hit-count or free-stack reads); input
// register and two-word queue accept while the back end works or result waits.
// Reset: all entries inactive, free numbers 0 upwards with 0 taken first; no
// clearing pass is needed. While i_stall is high the result word holds and
// the back end waits; once the queue fills, o_stall rises.
module breakpoint_pool_match_top
    import bpm_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [MODE_W-1:0]    i_mode,
    input  logic [IN_ADDR_W-1:0] i_target_address,
    input  logic [SLOT_W-1:0]    i_slot_number,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic                 o_ok,
    output logic                 o_hit,
    output logic [SLOT_W-1:0]    o_result_number,
    output logic [IN_ADDR_W-1:0] o_entry_address,
    output logic [HIT_W-1:0]     o_hit_count
);

    localparam int KEY_W = (ADDR_WIDTH < IN_ADDR_W) ? ADDR_WIDTH : IN_ADDR_W;
    localparam int CMD_W = MODE_W + KEY_W + SLOT_W + 1;

    logic             push;
    logic             full;
    logic             empty;
    logic             pop;
    logic [CMD_W-1:0] front_cmd;
    logic [CMD_W-1:0] queue_cmd;

    bpm_front #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_target_address (i_target_address),
        .i_slot_number    (i_slot_number),
        .o_push           (push),
        .o_cmd            (front_cmd),
        .i_full           (full)
    );

    bpm_queue #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (queue_cmd),
        .o_empty (empty)
    );

    bpm_exec #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .ADDR_WIDTH  (ADDR_WIDTH)
    ) u_exec (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (queue_cmd),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_ok            (o_ok),
        .o_hit           (o_hit),
        .o_result_number (o_result_number),
        .o_entry_address (o_entry_address),
        .o_hit_count     (o_hit_count)
    );

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bpm_pkg::*;

    localparam int N_SLOTS     = 32;
    localparam int RAND_WORDS  = 950;
    localparam int QUIET_WORDS = 120;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIX   = 2;
    localparam int PH_NOISE = 3;

    typedef struct packed {
        logic              ok;
        logic              hit;
        logic [SLOT_W-1:0] num;
        logic [31:0]       addr;
        logic [HIT_W-1:0]  cnt;
    } bp_result_t;

    typedef struct {
        t_mode             mode;
        logic [31:0]       addr;
        logic [SLOT_W-1:0] slot;
        bit                typed;
        bp_result_t        want;
    } stim_row_t;

    logic                 i_clk            = 1'b0;
    logic                 i_rst_n          = 1'b0;
    logic                 i_valid          = 1'b0;
    logic                 i_stall          = 1'b0;
    logic [MODE_W-1:0]    i_mode           = '0;
    logic [IN_ADDR_W-1:0] i_target_address = '0;
    logic [SLOT_W-1:0]    i_slot_number    = '0;
    logic                 o_stall;
    logic                 o_valid;
    logic                 o_ok;
    logic                 o_hit;
    logic [SLOT_W-1:0]    o_result_number;
    logic [IN_ADDR_W-1:0] o_entry_address;
    logic [HIT_W-1:0]     o_hit_count;

    breakpoint_pool_match_top u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_mode           (i_mode),
        .i_target_address (i_target_address),
        .i_slot_number    (i_slot_number),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_ok             (o_ok),
        .o_hit            (o_hit),
        .o_result_number  (o_result_number),
        .o_entry_address  (o_entry_address),
        .o_hit_count      (o_hit_count)
    );

    // pool shadow
    logic [SLOT_W-1:0] free_stk [N_SLOTS];
    int unsigned       free_cnt;
    bit                slot_act [N_SLOTS];
    logic [31:0]       slot_addr [N_SLOTS];
    logic [HIT_W-1:0]  slot_hits [N_SLOTS];
    int unsigned       slot_rank [N_SLOTS];
    int unsigned       act_cnt;

    bp_result_t  pending_results[$];
    stim_row_t   directed_rows[$];
    logic [31:0] addr_palette [8];

    int  mismatches   = 0;
    int  cycles       = 0;
    int  n_words      = 0;
    int  n_set        = 0;
    int  n_set_full   = 0;
    int  n_free       = 0;
    int  n_free_bad   = 0;
    int  n_check      = 0;
    int  n_check_hit  = 0;
    int  n_read       = 0;
    int  n_read_act   = 0;
    bit  tx_idle_en   = 1'b0;
    bit  rx_idle_en   = 1'b0;
    int  rx_burst     = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_results.size());
            $display("** breakpoint_pool_match_top: FAILED **");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall  <= 1'b0;
            rx_burst = 0;
        end else if (rx_burst > 0) begin
            rx_burst--;
            i_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            rx_burst = $urandom_range(1, 17) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        bp_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result word: ok=%0b hit=%0b num=%0d addr=%h cnt=%h",
                             o_ok, o_hit, o_result_number, o_entry_address, o_hit_count);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok || o_hit !== want.hit || o_result_number !== want.num
                    || o_entry_address !== want.addr || o_hit_count !== want.cnt) begin
                    if (mismatches < MAX_REPORTS)
                        $display({"mismatch at cycle %0d: exp ok=%0b hit=%0b num=%0d addr=%h",
                                  " cnt=%h, got ok=%0b hit=%0b num=%0d addr=%h cnt=%h"},
                                 cycles, want.ok, want.hit, want.num, want.addr, want.cnt,
                                 o_ok, o_hit, o_result_number, o_entry_address, o_hit_count);
                    mismatches++;
                end
            end
        end
    end

    function automatic bp_result_t pool_apply(t_mode m, logic [31:0] a, logic [SLOT_W-1:0] s);
        bp_result_t r;
        int best;
        r    = '0;
        best = -1;
        case (m)
            MODE_SET: begin
                if (free_cnt != 0) begin
                    free_cnt--;
                    best            = free_stk[free_cnt];
                    slot_act[best]  = 1'b1;
                    slot_addr[best] = a;
                    slot_hits[best] = '0;
                    slot_rank[best] = act_cnt;
                    act_cnt++;
                    r.ok  = 1'b1;
                    r.num = SLOT_W'(best);
                end
            end
            MODE_FREE: begin
                if (slot_act[s]) begin
                    slot_act[s] = 1'b0;
                    for (int i = 0; i < N_SLOTS; i++)
                        if (slot_act[i] && slot_rank[i] > slot_rank[s])
                            slot_rank[i]--;
                    act_cnt--;
                    free_stk[free_cnt] = s;
                    free_cnt++;
                    r.ok = 1'b1;
                end
            end
            MODE_CHECK: begin
                for (int i = 0; i < N_SLOTS; i++)
                    if (slot_act[i] && slot_addr[i] == a)
                        if (best < 0 || slot_rank[i] < slot_rank[best])
                            best = i;
                if (best >= 0) begin
                    if (slot_hits[best] != HIT_MAX)
                        slot_hits[best]++;
                    r.hit = 1'b1;
                    r.num = SLOT_W'(best);
                    r.cnt = slot_hits[best];
                end
            end
            default: begin
                r.num = s;
                if (slot_act[s]) begin
                    r.ok   = 1'b1;
                    r.addr = slot_addr[s];
                    r.cnt  = slot_hits[s];
                end
            end
        endcase
        return r;
    endfunction

    function automatic bit pick_active(output logic [SLOT_W-1:0] s);
        int live[$];
        s = '0;
        for (int i = 0; i < N_SLOTS; i++)
            if (slot_act[i])
                live.push_back(i);
        if (live.size() == 0)
            return 1'b0;
        s = SLOT_W'(live[$urandom_range(0, live.size() - 1)]);
        return 1'b1;
    endfunction

    task automatic add_row(t_mode m, logic [31:0] a, logic [SLOT_W-1:0] s, bit typed,
                           logic ok, logic hit, logic [SLOT_W-1:0] num, logic [31:0] ea,
                           logic [HIT_W-1:0] cnt);
        stim_row_t row;
        row.mode  = m;
        row.addr  = a;
        row.slot  = s;
        row.typed = typed;
        row.want  = '{ok: ok, hit: hit, num: num, addr: ea, cnt: cnt};
        directed_rows.push_back(row);
    endtask

    task automatic send_word(t_mode m, logic [31:0] a, logic [SLOT_W-1:0] s, bit typed,
                             bp_result_t want);
        bp_result_t got;
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_mode           <= m;
        i_target_address <= a;
        i_slot_number    <= s;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        got = pool_apply(m, a, s);
        pending_results.push_back(typed ? want : got);
        n_words++;
        case (m)
            MODE_SET: begin
                n_set++;
                if (!got.ok) n_set_full++;
            end
            MODE_FREE: begin
                n_free++;
                if (!got.ok) n_free_bad++;
            end
            MODE_CHECK: begin
                n_check++;
                if (got.hit) n_check_hit++;
            end
            default: begin
                n_read++;
                if (got.ok) n_read_act++;
            end
        endcase
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        int               n_rand;
        int               phase;
        int               phase_len;
        int               roll;
        t_mode            m;
        logic [31:0]      a;
        logic [SLOT_W-1:0] s;
        bp_result_t       none;

        none = '0;
        for (int i = 0; i < N_SLOTS; i++) begin
            free_stk[i] = SLOT_W'(N_SLOTS - 1 - i);
            slot_act[i] = 1'b0;
        end
        free_cnt = N_SLOTS;
        act_cnt  = 0;
        for (int i = 0; i < 8; i++)
            addr_palette[i] = $urandom();
        addr_palette[0] = 32'h0000_0000;
        addr_palette[1] = 32'hFFFF_FFFF;

        add_row(MODE_READ,  32'h0,         5'd0,  1, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_READ,  32'hFFFF_FFFF, 5'd31, 1, 0, 0, 5'd31, 32'h0,         32'd0);
        add_row(MODE_FREE,  32'h0,         5'd0,  1, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_FREE,  32'h0,         5'd31, 1, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_CHECK, 32'h0,         5'd0,  1, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_SET,   32'hFFFF_FFFF, 5'd0,  1, 1, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_SET,   32'h0,         5'd31, 1, 1, 0, 5'd1,  32'h0,         32'd0);
        add_row(MODE_SET,   32'hFFFF_FFFF, 5'd0,  1, 1, 0, 5'd2,  32'h0,         32'd0);
        add_row(MODE_CHECK, 32'hFFFF_FFFF, 5'd0,  1, 0, 1, 5'd0,  32'h0,         32'd1);
        add_row(MODE_CHECK, 32'hFFFF_FFFF, 5'd31, 1, 0, 1, 5'd0,  32'h0,         32'd2);
        add_row(MODE_CHECK, 32'h0,         5'd0,  1, 0, 1, 5'd1,  32'h0,         32'd1);
        add_row(MODE_READ,  32'h0,         5'd0,  1, 1, 0, 5'd0,  32'hFFFF_FFFF, 32'd2);
        add_row(MODE_FREE,  32'h0,         5'd0,  1, 1, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_FREE,  32'h0,         5'd0,  1, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_CHECK, 32'hFFFF_FFFF, 5'd0,  0, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_SET,   32'hFFFF_FFFF, 5'd0,  0, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_CHECK, 32'hFFFF_FFFF, 5'd0,  0, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_READ,  32'h0,         5'd2,  0, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_FREE,  32'h0,         5'd1,  0, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_SET,   32'h1234_5678, 5'd0,  0, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_READ,  32'h0,         5'd1,  0, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_CHECK, 32'h1234_5678, 5'd0,  0, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_READ,  32'hA5A5_5A5A, 5'd5,  0, 0, 0, 5'd0,  32'h0,         32'd0);
        add_row(MODE_CHECK, 32'h5A5A_A5A5, 5'd0,  0, 0, 0, 5'd0,  32'h0,         32'd0);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_word(directed_rows[k].mode, directed_rows[k].addr, directed_rows[k].slot,
                      directed_rows[k].typed, directed_rows[k].want);
        drain_results();

        n_rand = 0;
        phase  = PH_FILL;
        while (n_rand < RAND_WORDS) begin
            phase_len = $urandom_range(20, 80);
            if (RAND_WORDS - n_rand <= QUIET_WORDS) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
                phase_len  = RAND_WORDS - n_rand;
            end else begin
                tx_idle_en = ($urandom_range(0, 2) != 0);
                rx_idle_en = ($urandom_range(0, 2) != 0);
            end
            repeat (phase_len) begin
                roll = $urandom_range(0, 99);
                a    = ($urandom_range(0, 9) < 7) ? addr_palette[$urandom_range(0, 7)]
                                                  : $urandom();
                s    = SLOT_W'($urandom_range(0, N_SLOTS - 1));
                case (phase)
                    PH_FILL:  m = (roll < 80) ? MODE_SET : (roll < 92) ? MODE_CHECK
                                                                   : MODE_READ;
                    PH_DRAIN: m = (roll < 75) ? MODE_FREE : (roll < 88) ? MODE_CHECK
                                                                     : MODE_READ;
                    PH_MIX:   m = (roll < 45) ? MODE_CHECK : (roll < 60) ? MODE_READ
                                  : (roll < 80) ? MODE_SET : MODE_FREE;
                    default:  m = t_mode'($urandom_range(0, 3));
                endcase
                if (phase != PH_NOISE) begin
                    if (m == MODE_FREE && $urandom_range(0, 9) != 0)
                        void'(pick_active(s));
                    if (m == MODE_READ && $urandom_range(0, 2) != 0)
                        void'(pick_active(s));
                    if (m == MODE_CHECK && $urandom_range(0, 1) == 0 && pick_active(s))
                        a = slot_addr[s];
                end else begin
                    a = $urandom();
                end
                send_word(m, a, s, 1'b0, none);
                n_rand++;
            end
            if (n_rand == phase_len || $urandom_range(0, 3) == 0)
                drain_results();
            if (free_cnt == 0)
                phase = PH_DRAIN;
            else if (act_cnt == 0)
                phase = PH_FILL;
            else
                phase = $urandom_range(PH_FILL, PH_NOISE);
        end

        drain_results();
        repeat (12) @(posedge i_clk);
        $display("covered %0d words: %0d sets (%0d on a full pool), %0d frees (%0d refused)",
                 n_words, n_set, n_set_full, n_free, n_free_bad);
        $display("  %0d checks (%0d hits), %0d reads (%0d of active entries), %0d mismatches",
                 n_check, n_check_hit, n_read, n_read_act, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** breakpoint_pool_match_top: PASSED **");
        else
            $display("** breakpoint_pool_match_top: FAILED **");
        $finish;
    end

endmodule

// ===== breakpoint_pool_match_top.f =====
rtl/core/bpm_pkg.sv
rtl/core/bpm_ram.sv
rtl/core/bpm_front.sv
rtl/core/bpm_queue.sv
rtl/core/bpm_exec.sv
rtl/core/breakpoint_pool_match_top.sv
dv/tb.sv
